@@ src/rlsd_pkg.sv @@
// Shared definitions for the serial RGB LED driver: item kinds, register
// indexes, reset values, the configuration and result structs, and the
// divide-by-100 helper. No dependencies.
package rlsd_pkg;

  localparam int FRAME_BITS_DEF  = 24;
  localparam int DELAY_WIDTH_DEF = 20;

  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK       = 2'd0;
  localparam logic [1:0] KIND_STATUS     = 2'd1;
  localparam logic [1:0] KIND_BRIGHTNESS = 2'd2;
  localparam logic [1:0] KIND_COLOUR     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LATCH       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_DELAY = 3'd4;

  localparam logic [7:0]  ZERO_HIGH_RST   = 8'd2;
  localparam logic [7:0]  ONE_HIGH_RST    = 8'd4;
  localparam logic [7:0]  BIT_PERIOD_RST  = 8'd8;
  localparam logic [15:0] LATCH_RST       = 16'd1020;
  localparam logic [19:0] POWER_DELAY_RST = 20'd333334;

  localparam logic [7:0] BRIGHTNESS_MAX = 8'd100;
  localparam logic [7:0] SEEN_RST       = 8'hFF;
  localparam logic [7:0] STATUS_OFF     = 8'd0;
  localparam logic [7:0] STATUS_ON      = 8'd1;

  typedef struct packed {
    logic [7:0]  zero_high_ticks;
    logic [7:0]  one_high_ticks;
    logic [7:0]  bit_period_ticks;
    logic [15:0] latch_ticks;
    logic [19:0] power_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic        data_pin;
    logic        power_enable;
    logic        sending;
    logic [23:0] frame_word;
  } res_t;

  // Exact floor(p / 100) for p <= 25500 using a reciprocal multiply.
  function automatic logic [7:0] div100(input logic [14:0] p);
    logic [27:0] m;
    m = 28'(p) * 28'd5243;
    return m[26:19];
  endfunction

endpackage

@@ src/rlsd_scale.sv @@
// Brightness and colour holding registers with the channel products kept
// registered, and the divide-by-100 that yields the scaled GRB word.
// Depends on rlsd_pkg.
module rlsd_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  kind,
  input  logic [7:0]  write_value,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic [6:0]  brightness,
  output logic [23:0] scaled_word
);
  import rlsd_pkg::*;

  logic [7:0]  colour_red;
  logic [7:0]  colour_green;
  logic [7:0]  colour_blue;
  logic [14:0] prod_red;
  logic [14:0] prod_green;
  logic [14:0] prod_blue;
  logic [6:0]  bright_new;

  assign bright_new = (write_value > BRIGHTNESS_MAX) ? BRIGHTNESS_MAX[6:0] : write_value[6:0];

  // Products follow each colour or brightness write so the next tick sees them ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness   <= '0;
      colour_red   <= '0;
      colour_green <= '0;
      colour_blue  <= '0;
      prod_red     <= '0;
      prod_green   <= '0;
      prod_blue    <= '0;
    end else if (step) begin
      if (kind == KIND_COLOUR) begin
        colour_red   <= red;
        colour_green <= green;
        colour_blue  <= blue;
        prod_red     <= 15'(red) * 15'(brightness);
        prod_green   <= 15'(green) * 15'(brightness);
        prod_blue    <= 15'(blue) * 15'(brightness);
      end else if (kind == KIND_BRIGHTNESS) begin
        brightness <= bright_new;
        prod_red   <= 15'(colour_red) * 15'(bright_new);
        prod_green <= 15'(colour_green) * 15'(bright_new);
        prod_blue  <= 15'(colour_blue) * 15'(bright_new);
      end
    end
  end

  assign scaled_word = {div100(prod_green), div100(prod_red), div100(prod_blue)};

endmodule

@@ src/rlsd_core.sv @@
// Status tracking, power sequencing and bit waveform timing for one item
// per step; produces the next result word. Depends on rlsd_pkg.
module rlsd_core #(
  parameter int FRAME_BITS  = rlsd_pkg::FRAME_BITS_DEF,
  parameter int DELAY_WIDTH = rlsd_pkg::DELAY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [1:0]     kind,
  input  logic [7:0]     write_value,
  input  rlsd_pkg::cfg_t cfg,
  input  logic [6:0]     brightness,
  input  logic [23:0]    scaled_word,
  output rlsd_pkg::res_t result
);
  import rlsd_pkg::*;

  localparam int BI_W = $clog2(FRAME_BITS);
  localparam int CW   = (DELAY_WIDTH > 20) ? DELAY_WIDTH : 20;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BITS  = 2'd1;
  localparam logic [1:0] PH_LATCH = 2'd2;

  logic [7:0]             status_value, status_value_next;
  logic                   update_pending, update_pending_next;
  logic [7:0]             seen_status, seen_status_next;
  logic [7:0]             seen_brightness, seen_brightness_next;
  logic                   power_on, power_on_next;
  logic                   power_waiting, power_waiting_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic [23:0]            frame_buffer, frame_buffer_next;
  logic [1:0]             send_phase, send_phase_next;
  logic [BI_W-1:0]        bit_index, bit_index_next;
  logic [15:0]            slot_count, slot_count_next;

  logic                   need;
  logic [DELAY_WIDTH-1:0] delay_inc;
  logic [16:0]            slot_inc;
  logic [BI_W:0]          bit_inc;
  logic [BI_W-1:0]        bit_pos;
  logic [FRAME_BITS-1:0]  frame_ext;
  logic [7:0]             high_ticks;

  always_comb begin
    status_value_next    = status_value;
    update_pending_next  = update_pending;
    seen_status_next     = seen_status;
    seen_brightness_next = seen_brightness;
    power_on_next        = power_on;
    power_waiting_next   = power_waiting;
    delay_count_next     = delay_count;
    frame_buffer_next    = frame_buffer;
    send_phase_next      = send_phase;
    bit_index_next       = bit_index;
    slot_count_next      = slot_count;

    need = (seen_status != status_value) || (seen_brightness != {1'b0, brightness}) ||
           update_pending;
    delay_inc = (delay_count == '1) ? delay_count : delay_count + 1'b1;
    slot_inc  = {1'b0, slot_count} + 17'd1;
    bit_inc   = {1'b0, bit_index} + 1'b1;

    if (step) begin
      case (kind)
        KIND_STATUS: begin
          status_value_next = write_value;
        end
        KIND_COLOUR: begin
          update_pending_next = 1'b1;
        end
        KIND_BRIGHTNESS: begin
          // Held in the scaling unit.
        end
        default: begin
          if (send_phase == PH_BITS) begin
            if (slot_inc >= {9'd0, cfg.bit_period_ticks}) begin
              slot_count_next = '0;
              if (bit_inc >= (BI_W+1)'(FRAME_BITS)) begin
                send_phase_next = PH_LATCH;
                bit_index_next  = '0;
              end else begin
                bit_index_next = bit_inc[BI_W-1:0];
              end
            end else begin
              slot_count_next = slot_inc[15:0];
            end
          end else if (send_phase != PH_IDLE) begin
            if (slot_inc >= {1'b0, cfg.latch_ticks}) begin
              send_phase_next = PH_IDLE;
              slot_count_next = '0;
            end else begin
              slot_count_next = slot_inc[15:0];
            end
          end else begin
            seen_status_next     = status_value;
            seen_brightness_next = {1'b0, brightness};
            if (status_value == STATUS_OFF) begin
              power_on_next      = 1'b0;
              power_waiting_next = 1'b0;
              if (need) begin
                frame_buffer_next   = scaled_word;
                update_pending_next = 1'b0;
              end
            end else if (status_value == STATUS_ON) begin
              if (!power_on) begin
                power_on_next      = 1'b1;
                power_waiting_next = 1'b1;
                delay_count_next   = '0;
              end else if (power_waiting) begin
                if (CW'(delay_inc) < CW'(cfg.power_delay_ticks)) begin
                  delay_count_next = delay_inc;
                end else begin
                  frame_buffer_next   = scaled_word;
                  send_phase_next     = PH_BITS;
                  bit_index_next      = '0;
                  slot_count_next     = '0;
                  update_pending_next = 1'b0;
                  power_waiting_next  = 1'b0;
                  delay_count_next    = '0;
                end
              end else if (need) begin
                frame_buffer_next   = scaled_word;
                send_phase_next     = PH_BITS;
                bit_index_next      = '0;
                slot_count_next     = '0;
                update_pending_next = 1'b0;
              end
            end
          end
        end
      endcase
    end
  end

  // Leading bit positions beyond the 24-bit buffer go out as zeros.
  assign frame_ext  = FRAME_BITS'(frame_buffer_next);
  assign bit_pos    = BI_W'(FRAME_BITS - 1) - bit_index_next;
  assign high_ticks = frame_ext[bit_pos] ? cfg.one_high_ticks : cfg.zero_high_ticks;

  always_comb begin
    result.data_pin     = (send_phase_next == PH_BITS) && (slot_count_next < {8'd0, high_ticks});
    result.power_enable = power_on_next;
    result.sending      = (send_phase_next != PH_IDLE);
    result.frame_word   = frame_buffer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_value    <= '0;
      update_pending  <= 1'b0;
      seen_status     <= SEEN_RST;
      seen_brightness <= SEEN_RST;
      power_on        <= 1'b0;
      power_waiting   <= 1'b0;
      delay_count     <= '0;
      frame_buffer    <= '0;
      send_phase      <= PH_IDLE;
      bit_index       <= '0;
      slot_count      <= '0;
    end else begin
      status_value    <= status_value_next;
      update_pending  <= update_pending_next;
      seen_status     <= seen_status_next;
      seen_brightness <= seen_brightness_next;
      power_on        <= power_on_next;
      power_waiting   <= power_waiting_next;
      delay_count     <= delay_count_next;
      frame_buffer    <= frame_buffer_next;
      send_phase      <= send_phase_next;
      bit_index       <= bit_index_next;
      slot_count      <= slot_count_next;
    end
  end

endmodule

@@ src/rgb_led_serial_driver_unit.sv @@
// Top level of the serial RGB LED driver: input register, configuration
// registers, output register. Depends on rlsd_pkg, rlsd_scale, rlsd_core.
//
// Usage: each word on the input channel is a base-time tick (kind 0) or a
// write of status, brightness or colour. Every accepted word yields exactly
// one result word: data line level, power enable, sending flag and the
// current scaled GRB frame buffer. Timing registers are written through the
// cfg_write / cfg_index / cfg_data port; the user must write them only while
// the block is idle, as the block itself does not enforce it. An accepted
// word sits in the input register while the status/waveform logic works
// on it; the result is loaded into the output register when it is free. One
// word is accepted per cycle when the output side keeps up; the rate is set
// by the single update of the state registers per word. Brightness and
// colour products are registered at write time so a tick right after a
// write sees the new values.
// Reset clears all state to power off, status 0, brightness 0, colour 0 and
// restores the timing register defaults; no clearing pass is needed.
// When the receiver stalls, the result holds, the input register fills and
// in_ready drops until the result is taken.
module rgb_led_serial_driver_unit #(
  parameter int FRAME_BITS  = rlsd_pkg::FRAME_BITS_DEF,
  parameter int DELAY_WIDTH = rlsd_pkg::DELAY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [7:0]                       write_value,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             data_pin,
  output logic                             power_enable,
  output logic                             sending,
  output logic [23:0]                      frame_word,
  input  logic                             cfg_write,
  input  logic [rlsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rlsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rlsd_pkg::*;

  logic       in_full;
  logic [1:0] kind_r;
  logic [7:0] write_value_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic       step;
  cfg_t       cfg;
  res_t       result;
  res_t       result_r;
  logic [6:0] brightness;
  logic [23:0] scaled_word;

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r        <= kind;
      write_value_r <= write_value;
      red_r         <= red;
      green_r       <= green;
      blue_r        <= blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high_ticks   <= ZERO_HIGH_RST;
      cfg.one_high_ticks    <= ONE_HIGH_RST;
      cfg.bit_period_ticks  <= BIT_PERIOD_RST;
      cfg.latch_ticks       <= LATCH_RST;
      cfg.power_delay_ticks <= POWER_DELAY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ZERO_HIGH:   cfg.zero_high_ticks   <= cfg_data[7:0];
        CFG_ONE_HIGH:    cfg.one_high_ticks    <= cfg_data[7:0];
        CFG_BIT_PERIOD:  cfg.bit_period_ticks  <= cfg_data[7:0];
        CFG_LATCH:       cfg.latch_ticks       <= cfg_data[15:0];
        CFG_POWER_DELAY: cfg.power_delay_ticks <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  rlsd_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .kind        (kind_r),
    .write_value (write_value_r),
    .red         (red_r),
    .green       (green_r),
    .blue        (blue_r),
    .brightness  (brightness),
    .scaled_word (scaled_word)
  );

  rlsd_core #(
    .FRAME_BITS  (FRAME_BITS),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .kind        (kind_r),
    .write_value (write_value_r),
    .cfg         (cfg),
    .brightness  (brightness),
    .scaled_word (scaled_word),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign data_pin     = result_r.data_pin;
  assign power_enable = result_r.power_enable;
  assign sending      = result_r.sending;
  assign frame_word   = result_r.frame_word;

endmodule

@@ src/rlsd_checker.sv @@
// Port-level checks for the serial RGB LED driver and the bind that
// attaches them to the top level. Depends on rgb_led_serial_driver_unit.
module rlsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        data_pin,
  input logic        power_enable,
  input logic        sending,
  input logic [23:0] frame_word
);

  // A result that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_word) && $stable(data_pin) &&
    $stable(sending) && $stable(power_enable))
    else $error("result changed while stalled");

  // The data line is only driven high inside a frame.
  a_data_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_pin |-> sending)
    else $error("data line high outside a frame");

  // Frames only go out with the LED supply enabled.
  a_power_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && sending |-> power_enable)
    else $error("frame in progress without power");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind rgb_led_serial_driver_unit rlsd_checker u_rlsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data_pin     (data_pin),
  .power_enable (power_enable),
  .sending      (sending),
  .frame_word   (frame_word)
);
